// ===== sv/smx_pkg.sv =====
// ============================================================================
// Stack machine execute unit package
// Request and response payload types, command and fault codes, and default
// sizes shared by the execute unit and its memories.
// ============================================================================
package smx_pkg;

    // Default sizes, used as parameter defaults on the top level.
    localparam int STACK_DEPTH_DEF = 256;
    localparam int VAR_COUNT_DEF   = 64;
    localparam int PROG_DEPTH_DEF  = 1024;

    // Fixed field widths of the request and response payloads.
    localparam int CMD_W    = 4;
    localparam int DATA_W   = 32;
    localparam int VIDX_W   = 6;
    localparam int TIDX_W   = 10;
    localparam int NPC_W    = 11;
    localparam int DEPTH_W  = 9;
    localparam int FAULT_W  = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH_IMM  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_VAR  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_POP       = 4'd2;
    localparam logic [CMD_W-1:0] CMD_POP_STORE = 4'd3;
    localparam logic [CMD_W-1:0] CMD_ADD       = 4'd4;
    localparam logic [CMD_W-1:0] CMD_IFEQ      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_IFGT      = 4'd6;
    localparam logic [CMD_W-1:0] CMD_IFLT      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_JMP       = 4'd8;
    localparam logic [CMD_W-1:0] CMD_PRINT     = 4'd9;
    localparam logic [CMD_W-1:0] CMD_DUP       = 4'd10;
    localparam logic [CMD_W-1:0] CMD_MUL       = 4'd11;
    localparam logic [CMD_W-1:0] CMD_NOP       = 4'd12;

    // Fault codes.
    localparam logic [FAULT_W-1:0] FAULT_NONE      = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_UNDERFLOW = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] immediate;
        logic [VIDX_W-1:0]        var_index;
        logic [TIDX_W-1:0]        target_index;
        logic                     target_found;
    } smx_req_t;

    typedef struct packed {
        logic [NPC_W-1:0]         next_pc;
        logic signed [DATA_W-1:0] top_value;
        logic                     top_valid;
        logic                     print_valid;
        logic [DEPTH_W-1:0]       depth;
        logic [FAULT_W-1:0]       fault;
    } smx_rsp_t;

endpackage

// ===== sv/stack_machine_execute_unit.sv =====
// ============================================================================
// Stack machine execute unit
// Executes one stack-machine instruction per request and returns one
// response with the new program counter, top of stack, depth and fault.
// ============================================================================
//
//  Channel | Handshake            | Payload    | Meaning
//  --------+----------------------+------------+------------------------------
//  request | req_valid/req_ready  | req        | one instruction to execute
//  respond | rsp_valid/rsp_ready  | rsp        | machine state after it
//
//  Every instruction passes through an accept cycle that issues the
//  memory reads, and an execute cycle that uses the read data, writes back
//  and loads the response register. A new request is accepted only after
//  the previous one has committed, since the stack and variable RAMs have
//  registered reads. After reset the variable store is cleared in a pass
//  over all VAR_COUNT entries, during which no request is accepted.
//  A pending response does not block acceptance; the execute cycle waits
//  only while the response register is still full and not being taken.
//
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int VAR_COUNT   = smx_pkg::VAR_COUNT_DEF,
    parameter int PROG_DEPTH  = smx_pkg::PROG_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  smx_pkg::smx_req_t req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output smx_pkg::smx_rsp_t rsp
);
    import smx_pkg::*;

    // Stack pointer holds 0..STACK_DEPTH; the stack RAM address is one bit
    // narrower when the depth is a power of two.
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int SA_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int VAR_AW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    // The program counter saturates at PROG_DEPTH + 1.
    localparam int PC_W   = $clog2(PROG_DEPTH + 2);
    // Unsaturated next counter: pc + 2 or target + 1 must both fit.
    localparam int NX_W   = ((PC_W > TIDX_W) ? PC_W : TIDX_W) + 1;

    localparam logic [PC_W-1:0] PC_LIMIT = PC_W'(PROG_DEPTH + 1);

    // One-hot controller states.
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } smx_state_t;

    smx_state_t          state_reg, state_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [DATA_W-1:0]   top_reg, top_next;
    logic [VAR_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    smx_req_t            req_reg;
    logic                rsp_valid_reg;
    smx_rsp_t            rsp_reg;

    logic                accept;
    logic                commit;

    // Memory ports.
    logic                stk_we;
    logic [SA_W-1:0]     stk_waddr;
    logic [DATA_W-1:0]   stk_wdata;
    logic [SA_W-1:0]     stk_raddr;
    logic [DATA_W-1:0]   stk_rdata;
    logic                var_we;
    logic [VAR_AW-1:0]   var_waddr;
    logic [DATA_W-1:0]   var_wdata;
    logic [VAR_AW-1:0]   var_raddr;
    logic [DATA_W-1:0]   var_rdata;

    // Execute-cycle decode.
    logic                empty;
    logic                full;
    logic                two_or_more;
    logic                var_ok;
    logic                found;
    logic                taken;
    logic [DATA_W-1:0]   var_value;
    logic [DATA_W-1:0]   product;
    logic [NX_W-1:0]     nx;
    logic [FAULT_W-1:0]  fault_c;
    logic                printed;
    logic                exec_var_we;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    // The execute cycle completes only when the response register can take
    // the result; until then nothing is written back.
    assign commit    = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);

    // Reads are issued only in the accept cycle. The previous instruction
    // wrote back in its execute cycle, before this accept cycle, so a read
    // never meets a write to the same entry in the same cycle.
    // The stack read fetches the entry just below the cached top.
    assign stk_raddr = SA_W'(sp_reg - SP_W'(2));
    assign var_raddr = VAR_AW'(req.var_index);

    smx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH),
        .AW    (SA_W)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_en   (accept),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    smx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VAR_COUNT),
        .AW    (VAR_AW)
    ) u_var_ram (
        .clk     (clk),
        .wr_en   (var_we),
        .wr_addr (var_waddr),
        .wr_data (var_wdata),
        .rd_en   (accept),
        .rd_addr (var_raddr),
        .rd_data (var_rdata)
    );

    // The clearing pass owns the variable write port; afterwards only the
    // execute cycle writes it, for a pop-and-store.
    assign var_we    = (state_reg == ST_CLEAR) || exec_var_we;
    assign var_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : VAR_AW'(req_reg.var_index);
    assign var_wdata = (state_reg == ST_CLEAR) ? '0 : top_reg;

    assign empty       = (sp_reg == '0);
    assign full        = (sp_reg == SP_W'(STACK_DEPTH));
    assign two_or_more = (sp_reg >= SP_W'(2));
    assign var_ok      = (32'(req_reg.var_index) < 32'(VAR_COUNT));
    // A label index beyond the program counts as a missing label.
    assign found       = req_reg.target_found
                         && (32'(req_reg.target_index) < 32'(PROG_DEPTH));
    assign var_value   = var_ok ? var_rdata : '0;
    assign product     = stk_rdata * top_reg;

    always_comb
    begin
        case (req_reg.cmd)
            CMD_IFEQ: taken = (top_reg == '0);
            CMD_IFGT: taken = (top_reg != '0) && !top_reg[DATA_W-1];
            CMD_IFLT: taken = top_reg[DATA_W-1];
            default:  taken = 1'b0;
        endcase
    end

    // Instruction execution: one read-modify-write of the stack with the
    // top entry cached in top_reg.
    always_comb
    begin
        sp_next     = sp_reg;
        top_next    = top_reg;
        nx          = NX_W'(pc_reg) + NX_W'(1);
        fault_c     = FAULT_NONE;
        printed     = 1'b0;
        stk_we      = 1'b0;
        stk_waddr   = SA_W'(sp_reg);
        stk_wdata   = top_reg;
        exec_var_we = 1'b0;

        case (req_reg.cmd)
            CMD_PUSH_IMM, CMD_PUSH_VAR, CMD_DUP:
            begin
                if ((req_reg.cmd == CMD_DUP) && empty)
                begin
                    fault_c = FAULT_UNDERFLOW;
                end
                else if (full)
                begin
                    fault_c = FAULT_OVERFLOW;
                end
                else
                begin
                    if (req_reg.cmd == CMD_PUSH_IMM)
                    begin
                        stk_wdata = req_reg.immediate;
                    end
                    else if (req_reg.cmd == CMD_PUSH_VAR)
                    begin
                        stk_wdata = var_value;
                    end
                    stk_we   = commit;
                    top_next = stk_wdata;
                    sp_next  = sp_reg + SP_W'(1);
                end
            end
            CMD_POP, CMD_POP_STORE:
            begin
                if (empty)
                begin
                    fault_c = FAULT_UNDERFLOW;
                end
                else
                begin
                    exec_var_we = commit && (req_reg.cmd == CMD_POP_STORE) && var_ok;
                    top_next    = stk_rdata;
                    sp_next     = sp_reg - SP_W'(1);
                end
            end
            CMD_ADD, CMD_MUL:
            begin
                if (!two_or_more)
                begin
                    fault_c = FAULT_UNDERFLOW;
                end
                else
                begin
                    stk_wdata = (req_reg.cmd == CMD_ADD) ? stk_rdata + top_reg : product;
                    stk_waddr = SA_W'(sp_reg - SP_W'(2));
                    stk_we    = commit;
                    top_next  = stk_wdata;
                    sp_next   = sp_reg - SP_W'(1);
                end
            end
            CMD_IFEQ, CMD_IFGT, CMD_IFLT:
            begin
                if (empty)
                begin
                    fault_c = FAULT_UNDERFLOW;
                end
                else if (taken)
                begin
                    nx = found ? NX_W'(req_reg.target_index) + NX_W'(1)
                               : NX_W'(pc_reg) + NX_W'(2);
                end
            end
            CMD_JMP:
            begin
                if (found)
                begin
                    nx = NX_W'(req_reg.target_index);
                end
            end
            CMD_PRINT:
            begin
                printed = !empty;
            end
            default:
            begin
                // Nop and the unused codes only advance the counter.
            end
        endcase

        pc_next = (nx > NX_W'(PC_LIMIT)) ? PC_LIMIT : PC_W'(nx);
    end

    // Controller: clearing pass, idle, execute.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + VAR_AW'(1);
                if (clr_cnt_reg == VAR_AW'(VAR_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            sp_reg        <= '0;
            pc_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (commit)
            begin
                sp_reg        <= sp_next;
                pc_reg        <= pc_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (commit)
        begin
            top_reg             <= top_next;
            rsp_reg.next_pc     <= NPC_W'(pc_next);
            rsp_reg.top_value   <= (sp_next != '0) ? top_next : '0;
            rsp_reg.top_valid   <= (sp_next != '0);
            rsp_reg.print_valid <= printed;
            rsp_reg.depth       <= DEPTH_W'(sp_next);
            rsp_reg.fault       <= fault_c;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An accepted request always moves the controller into its execute cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted request did not enter execute");

    // The stack pointer never passes the stack depth.
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    // A faulting instruction leaves the stack depth as it was.
    a_fault_keeps_sp: assert property (@(posedge clk) disable iff (!rst_n)
        commit && (fault_c != FAULT_NONE) |=> $stable(sp_reg))
        else $error("faulting instruction changed the stack");

    // A new response appears only after an execute cycle.
    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("response raised outside execute");

    // No stack memory write happens outside a committing execute cycle.
    a_stk_write_commit: assert property (@(posedge clk) disable iff (!rst_n)
        stk_we |-> commit)
        else $error("stack written without commit");

endmodule

// ===== sv/smx_ram.sv =====
// ============================================================================
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered and holds
// its value while no read is issued.
// ============================================================================
module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
